// File: sv/tlfs_pkg.sv
// types and constants shared by the two-level feedback scheduler
`timescale 1ns / 1ps

package tlfs_pkg;

  localparam logic [7:0] QUANTUM_RESET = 8'd4;

  typedef enum logic {
    REQ_ADMIT = 1'b0,
    REQ_SLICE = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    EV_ADMITTED        = 3'd0,
    EV_ADMIT_DROPPED   = 3'd1,
    EV_REQUEUED        = 3'd2,
    EV_FINISHED        = 3'd3,
    EV_IDLE            = 3'd4,
    EV_REQUEUE_DROPPED = 3'd5
  } event_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    req_e       req_type;
    logic [7:0] task_id;
    logic [7:0] service_time;
  } req_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] out_task_id;
    logic [7:0] time_left;
    logic       from_high;
  } res_t;

  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] task_time;
  } entry_t;

endpackage

// File: sv/two_level_feedback_scheduler.sv
// two-level feedback scheduler over two circular queues held in memories
// timing: admit and idle slice beats give their result in the cycle after acceptance,
//   a slice that pops a task gives it after the registered memory read and the update in ST_READ
// throughput: one beat per cycle for admits and idle slices while the output is not stalled;
//   a slice that pops a task stalls new beats while the queue memories are read and updated
// reset: queues empty, quantum 4, output empty; memory contents are not cleared
`timescale 1ns / 1ps

module two_level_feedback_scheduler
  import tlfs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_beat_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       out_beat_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  entry_t high_mem [QUEUE_DEPTH];
  entry_t low_mem  [QUEUE_DEPTH];
  entry_t high_rdata_q, low_rdata_q;

  state_e          state_q, state_d;
  logic [PtrW-1:0] high_head_q, high_head_d, high_tail_q, high_tail_d;
  logic [PtrW-1:0] low_head_q, low_head_d, low_tail_q, low_tail_d;
  logic [CntW-1:0] high_count_q, high_count_d, low_count_q, low_count_d;
  logic [7:0]      quantum_q;
  logic            out_valid_q, out_valid_d;
  res_t            out_q, out_d;

  logic   accept;
  logic   high_we, low_we;
  entry_t high_wdata, low_wdata;
  entry_t popped;
  logic   pop_high;
  logic   low_full;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    if (ptr == PtrLast) begin
      nxt = '0;
    end else begin
      nxt = ptr + PtrW'(1);
    end
    return nxt;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  always_comb begin
    state_d      = state_q;
    high_head_d  = high_head_q;
    high_tail_d  = high_tail_q;
    low_head_d   = low_head_q;
    low_tail_d   = low_tail_q;
    high_count_d = high_count_q;
    low_count_d  = low_count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    high_we      = 1'b0;
    low_we       = 1'b0;
    high_wdata   = '{task_id: in_beat_i.task_id, task_time: in_beat_i.service_time};
    pop_high     = (high_count_q != '0);
    popped       = pop_high ? high_rdata_q : low_rdata_q;
    low_full     = pop_high && (low_count_q == CntFull);
    low_wdata    = '{task_id: popped.task_id, task_time: popped.task_time - quantum_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_beat_i.req_type)
            REQ_ADMIT: begin
              out_valid_d = 1'b1;
              out_d.out_task_id = in_beat_i.task_id;
              out_d.time_left   = in_beat_i.service_time;
              out_d.from_high   = 1'b0;
              if (high_count_q == CntFull) begin
                out_d.event_res = EV_ADMIT_DROPPED;
              end else begin
                out_d.event_res = EV_ADMITTED;
                high_we      = 1'b1;
                high_tail_d  = next_ptr(high_tail_q);
                high_count_d = high_count_q + CntW'(1);
              end
            end
            REQ_SLICE: begin
              if (high_count_q == '0 && low_count_q == '0) begin
                out_valid_d = 1'b1;
                out_d = '{event_res: EV_IDLE, out_task_id: 8'd0, time_left: 8'd0,
                          from_high: 1'b0};
              end else begin
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_d.out_task_id = popped.task_id;
        out_d.from_high   = pop_high;
        if (pop_high) begin
          high_head_d  = next_ptr(high_head_q);
          high_count_d = high_count_q - CntW'(1);
        end else begin
          low_head_d  = next_ptr(low_head_q);
          low_count_d = low_count_q - CntW'(1);
        end
        if (popped.task_time > quantum_q) begin
          out_d.time_left = low_wdata.task_time;
          if (low_full) begin
            out_d.event_res = EV_REQUEUE_DROPPED;
          end else begin
            out_d.event_res = EV_REQUEUED;
            low_we      = 1'b1;
            low_tail_d  = next_ptr(low_tail_q);
            low_count_d = pop_high ? low_count_q + CntW'(1) : low_count_q;
          end
        end else begin
          out_d.event_res = EV_FINISHED;
          out_d.time_left = 8'd0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      high_head_q  <= '0;
      high_tail_q  <= '0;
      low_head_q   <= '0;
      low_tail_q   <= '0;
      high_count_q <= '0;
      low_count_q  <= '0;
      quantum_q    <= QUANTUM_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      high_head_q  <= high_head_d;
      high_tail_q  <= high_tail_d;
      low_head_q   <= low_head_d;
      low_tail_q   <= low_tail_d;
      high_count_q <= high_count_d;
      low_count_q  <= low_count_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // high queue memory
  always_ff @(posedge clk_i) begin
    if (high_we) begin
      high_mem[high_tail_q] <= high_wdata;
    end
    high_rdata_q <= high_mem[high_head_q];
  end

  // low queue memory
  always_ff @(posedge clk_i) begin
    if (low_we) begin
      low_mem[low_tail_q] <= low_wdata;
    end
    low_rdata_q <= low_mem[low_head_q];
  end

endmodule
